>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock edge outside reset
`define AST_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dda checker: property violated");

// Condition that must never be true on a clock edge outside reset
`define AST_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dda checker: forbidden condition seen");

`endif

>>> hdl/dda_pkg.sv
// Shared constants, types and helpers of the DDA line rasterizer
package dda_pkg;

	// coordinate field width and tile bound
	localparam int COORD_W   = 6;
	localparam int COORD_MAX = 63;

	// default fraction bits of the fixed-point position
	localparam int FRAC_BITS_DEF = 16;

	// packed stream widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	// saturate a coordinate to the tile bound
	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
		logic [COORD_W-1:0] lim;
		lim = COORD_W'(COORD_MAX);
		return (v > lim) ? lim : v;
	endfunction

endpackage

>>> hdl/dda_divider.sv
// Restoring divider, one quotient bit per cycle: (numer << FRAC_BITS) / denom
module dda_divider #(
	parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dda_pkg::COORD_W-1:0] numer,
	input  logic [dda_pkg::COORD_W-1:0] denom,
	output logic                        done,
	output logic [FRAC_BITS:0]          quot
);

	localparam int NW    = dda_pkg::COORD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NW);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [NW-1:0]               num_q;
	logic [FRAC_BITS:0]          quot_q;
	logic [dda_pkg::COORD_W-1:0] den_q;
	logic [dda_pkg::COORD_W-1:0] rem_q;

	logic [dda_pkg::COORD_W:0]   trial;
	logic                        fits;
	logic [dda_pkg::COORD_W:0]   diff;

	// one shift-and-subtract step
	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		fits  = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	// control: busy over NW steps, done pulse after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out, quotient shifts in
	// quotient never exceeds 1.0 since numer <= denom, so the upper bits stay zero
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {numer, {FRAC_BITS{1'b0}}};
			den_q  <= denom;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= fits ? diff[dda_pkg::COORD_W-1:0] : trial[dda_pkg::COORD_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-1:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hdl/dda_line_rasterizer.sv
// A line of nonzero length shows its first pixel once the bit-serial divider is done and
// the increments are loaded; a zero-length line shows it in the cycle after acceptance.
// Pixels go out one per cycle while m_tready is high; the block takes one line at a time.
// Reset: arst_n clears the sequencer, divider control and output valid at once;
// the block is ready for a line in the first cycle after reset.
module dda_line_rasterizer #(
	parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input line stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dda_pkg::S_TDATA_W-1:0] s_tdata,  // start_x, start_y, end_x, end_y
	// output pixel stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dda_pkg::M_TDATA_W-1:0] m_tdata,  // pixel_x, pixel_y, 4'b0 pad
	output logic                          m_tlast   // last_pixel
);

	localparam int CW    = dda_pkg::COORD_W;
	localparam int ACC_W = CW + FRAC_BITS + 1;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int INC_W = FRAC_BITS + 2;

	dda_pkg::state_t state_q, state_d;

	logic [ACC_W-1:0] acc_x_q, acc_y_q;
	logic [INC_W-1:0] inc_x_q, inc_y_q;
	logic [CW-1:0]    steps_q;
	logic             neg_x_q, neg_y_q, x_major_q;

	logic [CW-1:0] x0, y0, x1, y1, adx, ady, steps, minor;
	logic          neg_x, neg_y, x_major;
	logic          in_beat, out_beat, div_start, div_done;
	logic [Q_W-1:0] div_quot;
	logic [Q_W-1:0] one_mag;
	logic [INC_W-1:0] inc_major, inc_minor;
	logic [ACC_W-1:0] half, rnd_x, rnd_y;

	// clamp and span decode of the incoming line
	always_comb begin
		x0      = dda_pkg::clamp_coord(s_tdata[5:0]);
		y0      = dda_pkg::clamp_coord(s_tdata[11:6]);
		x1      = dda_pkg::clamp_coord(s_tdata[17:12]);
		y1      = dda_pkg::clamp_coord(s_tdata[23:18]);
		neg_x   = (x1 < x0);
		neg_y   = (y1 < y0);
		adx     = neg_x ? (x0 - x1) : (x1 - x0);
		ady     = neg_y ? (y0 - y1) : (y1 - y0);
		x_major = (adx >= ady);
		steps   = x_major ? adx : ady;
		minor   = x_major ? ady : adx;
	end

	assign in_beat   = s_tvalid && s_tready;
	assign out_beat  = m_tvalid && m_tready;
	assign div_start = in_beat && (steps != '0);

	// minor-axis increment magnitude
	dda_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (minor),
		.denom (steps),
		.done  (div_done),
		.quot  (div_quot)
	);

	// signed increments: major axis moves exactly one pixel per step
	always_comb begin
		one_mag   = {1'b1, {FRAC_BITS{1'b0}}};
		inc_major = {1'b0, one_mag};
		inc_minor = {1'b0, div_quot};
		if (x_major_q ? neg_x_q : neg_y_q)
			inc_major = -inc_major;
		if (x_major_q ? neg_y_q : neg_x_q)
			inc_minor = -inc_minor;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			dda_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = (steps == '0) ? dda_pkg::ST_EMIT : dda_pkg::ST_DIV;
			end
			dda_pkg::ST_DIV: begin
				if (div_done)
					state_d = dda_pkg::ST_EMIT;
			end
			dda_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready && (steps_q == '0))
					state_d = dda_pkg::ST_IDLE;
			end
			default: begin
				state_d = dda_pkg::ST_IDLE;
			end
		endcase
	end

	// line setup, increment load and per-pixel stepping
	always_ff @(posedge clk) begin
		if (in_beat) begin
			acc_x_q   <= {1'b0, x0, {FRAC_BITS{1'b0}}};
			acc_y_q   <= {1'b0, y0, {FRAC_BITS{1'b0}}};
			inc_x_q   <= '0;
			inc_y_q   <= '0;
			steps_q   <= steps;
			neg_x_q   <= neg_x;
			neg_y_q   <= neg_y;
			x_major_q <= x_major;
		end else if (div_done) begin
			inc_x_q <= x_major_q ? inc_major : inc_minor;
			inc_y_q <= x_major_q ? inc_minor : inc_major;
		end else if (out_beat && (steps_q != '0)) begin
			acc_x_q <= acc_x_q + {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
			acc_y_q <= acc_y_q + {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
			steps_q <= steps_q - CW'(1);
		end
	end

	// round half up to whole pixels
	always_comb begin
		half  = ACC_W'(1) << (FRAC_BITS - 1);
		rnd_x = acc_x_q + half;
		rnd_y = acc_y_q + half;
	end

	assign m_tdata = {4'b0000, rnd_y[FRAC_BITS+CW-1:FRAC_BITS], rnd_x[FRAC_BITS+CW-1:FRAC_BITS]};
	assign m_tlast = (steps_q == '0);

endmodule

>>> hdl/dda_chk.sv
// Port-level checker for the DDA line rasterizer, bound to the top level
`include "assert_macros.svh"

module dda_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dda_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tlast
);

	// one line at a time: never ready for input while pixels are offered
	`AST_NEVER(a_no_overlap, clk, arst_n, s_tready && m_tvalid)

	// an accepted line takes the input side out of ready
	`AST_PROP(a_busy_after_in, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)

	// a stalled pixel beat holds its payload
	`AST_PROP(a_out_hold, clk, arst_n,
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

	// the last pixel ends the line: output goes idle and input reopens
	`AST_PROP(a_last_ends, clk, arst_n,
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))

endmodule

bind dda_line_rasterizer dda_chk u_dda_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
